// ----- rtl/fsc_pkg.sv -----
// Shared types and constants for the field sensor calibrate-and-steer block.
// No dependencies; used by the front end, queue, divider, back end and top level.
`timescale 1ns / 1ps
package fsc_pkg;
  localparam int unsigned SPF_DEFAULT = 6;
  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned SUM_W       = 15;
  localparam int unsigned LEVEL_W     = 7;
  localparam int unsigned STEER_W     = 18;
  localparam int unsigned NUM_W       = 22;   // divider dividend / quotient width
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;
  localparam logic [6:0] PCT_SCALE = 7'd100;
  localparam logic [16:0] STEER_SCALE = 17'd128000;  // 500 * 2^8

  typedef struct packed {
    logic [2:0][SUM_W-1:0] sums;
    logic [2:0][SUM_W-1:0] peaks;
  } frame_t;
endpackage

// ----- rtl/fsc_front.sv -----
// Front end: accepts sample words, accumulates frame sums, tracks peaks.
// Depends on fsc_pkg; pushes one frame_t per closed frame into the queue.
`timescale 1ns / 1ps
module fsc_front #(
  parameter int unsigned SAMPLES_PER_FRAME = fsc_pkg::SPF_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [3*fsc_pkg::SAMPLE_W-1:0] samples_i,
  input  logic                         calib_enable_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output fsc_pkg::frame_t              q_data_o
);
  localparam int unsigned CNT_W = (SAMPLES_PER_FRAME > 1) ? $clog2(SAMPLES_PER_FRAME) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES_PER_FRAME - 1);

  logic [2:0][fsc_pkg::SUM_W-1:0] sums_q, sums_d, peak_q, peak_d, add_sums;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic idle_q, idle_d, close, accept;

  assign close      = (cnt_q == LAST);
  assign in_ready_o = !(close && q_full_i);
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && close;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      add_sums[i] = sums_q[i] + fsc_pkg::SUM_W'(
        {samples_i[i*fsc_pkg::SAMPLE_W + 1 +: fsc_pkg::SAMPLE_W-1], 1'b0});
    end
    sums_d = sums_q;
    peak_d = peak_q;
    cnt_d  = cnt_q;
    idle_d = idle_q;
    if (accept) begin
      if (close) begin
        if (calib_enable_i) begin
          idle_d = 1'b0;
          for (int i = 0; i < 3; i++) begin
            // the first calibrating frame starts from cleared peaks
            if (idle_q || add_sums[i] > peak_q[i]) peak_d[i] = add_sums[i];
          end
        end else begin
          idle_d = 1'b1;
        end
        sums_d = '0;
        cnt_d  = '0;
      end else begin
        sums_d = add_sums;
        cnt_d  = cnt_q + 1'b1;
      end
    end
  end

  assign q_data_o.sums  = add_sums;
  assign q_data_o.peaks = peak_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q <= '0;
      peak_q <= '0;
      cnt_q  <= '0;
      idle_q <= 1'b1;
    end else begin
      sums_q <= sums_d;
      peak_q <= peak_d;
      cnt_q  <= cnt_d;
      idle_q <= idle_d;
    end
  end
endmodule

// ----- rtl/fsc_fifo.sv -----
// Two-entry queue of closed frames between front and back ends.
// Depends on fsc_pkg for the frame_t entry type.
`timescale 1ns / 1ps
module fsc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fsc_pkg::frame_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output fsc_pkg::frame_t data_o
);
  fsc_pkg::frame_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

// ----- rtl/fsc_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on fsc_pkg for widths; shared by the level and steering steps.
`timescale 1ns / 1ps
module fsc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fsc_pkg::NUM_W-1:0]   num_i,
  input  logic [fsc_pkg::SUM_W-1:0]   den_i,
  output logic                        done_o,
  output logic [fsc_pkg::NUM_W-1:0]   quot_o
);
  localparam int unsigned CW = $clog2(fsc_pkg::NUM_W + 1);

  logic [fsc_pkg::NUM_W-1:0] quot_q;
  logic [fsc_pkg::SUM_W-1:0] rem_q, den_q;
  logic [fsc_pkg::SUM_W:0]   rem_sh;
  logic [CW-1:0]             cnt_q;
  logic                      busy_q, done_q;

  assign rem_sh = {rem_q, quot_q[fsc_pkg::NUM_W-1]};
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(fsc_pkg::NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out of the top of quot_q as quotient bits enter the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q  <= fsc_pkg::SUM_W'(rem_sh - {1'b0, den_q});
        quot_q <= {quot_q[fsc_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[fsc_pkg::SUM_W-1:0];
        quot_q <= {quot_q[fsc_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end
endmodule

// ----- rtl/fsc_back.sv -----
// Back end: levels, square roots and steering error for one frame at a time.
// Depends on fsc_pkg and fsc_div; drives the output register.
`timescale 1ns / 1ps
module fsc_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_empty_i,
  input  fsc_pkg::frame_t                    q_data_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [3*fsc_pkg::LEVEL_W-1:0]      levels_o,
  output logic [fsc_pkg::STEER_W-1:0]        steer_o,
  output logic                               div_zero_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_LSTART, S_LWAIT, S_SQRT, S_MUL, S_DSTART, S_DWAIT, S_DONE
  } state_e;

  localparam int unsigned RT_W = 20;   // root of a 7-bit value in Q16
  localparam int unsigned SQ_STEPS = RT_W;
  localparam int unsigned SQ_CW = $clog2(SQ_STEPS + 1);

  state_e state_q;
  fsc_pkg::frame_t frm_q;
  logic [2:0][fsc_pkg::LEVEL_W-1:0] lvl_q;
  logic [1:0] ch_q;
  logic sq_sel_q;                       // 0: left channel, 1: right channel
  logic [2*RT_W-1:0] sq_src_q;
  logic [RT_W+2:0] sq_rem_q;
  logic [RT_W-1:0] sq_root_q, root0_q;
  logic [SQ_CW-1:0] sq_cnt_q;
  logic neg_q;
  logic [36:0] prod_q;
  logic [8:0] den_sum;
  logic out_valid_q, div_zero_q;
  logic [fsc_pkg::STEER_W-1:0] steer_q;
  // output register, so the next frame can be worked on while a word waits
  logic [3*fsc_pkg::LEVEL_W-1:0] out_lvl_q;
  logic [fsc_pkg::STEER_W-1:0] out_steer_q;
  logic out_dz_q;
  logic out_load;

  logic div_start, div_done;
  logic [fsc_pkg::NUM_W-1:0] div_num, div_quot;
  logic [fsc_pkg::SUM_W-1:0] div_den;
  logic [RT_W+2:0] sq_rem_sh, sq_trial;
  logic [RT_W-1:0] diff, sq_next_root;

  assign den_sum = 9'(lvl_q[0]) + 9'(lvl_q[1]) + 9'(lvl_q[2]);
  assign div_start = (state_q == S_LSTART) || (state_q == S_DSTART);
  always_comb begin
    if (state_q == S_LSTART) begin
      div_num = fsc_pkg::NUM_W'(frm_q.sums[ch_q] * fsc_pkg::PCT_SCALE);
      div_den = frm_q.peaks[ch_q];
    end else begin
      div_num = fsc_pkg::NUM_W'(prod_q[36:16]);
      div_den = fsc_pkg::SUM_W'(den_sum);
    end
  end

  fsc_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quot)
  );

  assign sq_rem_sh = {sq_rem_q[RT_W:0], sq_src_q[2*RT_W-1 -: 2]};
  assign sq_trial  = {1'b0, sq_root_q, 2'b01};
  assign sq_next_root = {sq_root_q[RT_W-2:0], (sq_rem_sh >= sq_trial)};
  assign diff = (root0_q >= sq_root_q) ? root0_q - sq_root_q : sq_root_q - root0_q;

  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign q_pop_o     = (state_q == S_IDLE) && !q_empty_i;
  assign out_valid_o = out_valid_q;
  assign levels_o    = out_lvl_q;
  assign steer_o     = out_steer_q;
  assign div_zero_o  = out_dz_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_lvl_q   <= lvl_q;
      out_steer_q <= steer_q;
      out_dz_q    <= div_zero_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      ch_q        <= 2'd0;
      sq_sel_q    <= 1'b0;
      sq_cnt_q    <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            frm_q   <= q_data_i;
            ch_q    <= 2'd0;
            state_q <= S_LSTART;
          end
        end
        S_LSTART: state_q <= S_LWAIT;
        S_LWAIT: begin
          if (div_done) begin
            if (frm_q.peaks[ch_q] == '0) begin
              lvl_q[ch_q] <= (frm_q.sums[ch_q] != '0) ? fsc_pkg::LEVEL_MAX : '0;
            end else if (div_quot > fsc_pkg::NUM_W'(fsc_pkg::LEVEL_MAX)) begin
              lvl_q[ch_q] <= fsc_pkg::LEVEL_MAX;
            end else begin
              lvl_q[ch_q] <= div_quot[fsc_pkg::LEVEL_W-1:0];
            end
            if (ch_q == 2'd2) begin
              sq_sel_q <= 1'b0;
              state_q  <= S_SQRT;
              sq_cnt_q <= '0;
              sq_rem_q <= '0;
              sq_root_q <= '0;
              sq_src_q <= {1'b0, lvl_q[0], 32'd0};
            end else begin
              ch_q    <= ch_q + 2'd1;
              state_q <= S_LSTART;
            end
          end
        end
        S_SQRT: begin
          if (sq_cnt_q == SQ_CW'(SQ_STEPS - 1) && !sq_sel_q) begin
            // keep the left root, restart on the right channel next cycle
            root0_q   <= sq_next_root;
            sq_sel_q  <= 1'b1;
            sq_cnt_q  <= '0;
            sq_rem_q  <= '0;
            sq_root_q <= '0;
            sq_src_q  <= {1'b0, lvl_q[2], 32'd0};
          end else begin
            sq_src_q  <= {sq_src_q[2*RT_W-3:0], 2'b00};
            sq_root_q <= sq_next_root;
            if (sq_rem_sh >= sq_trial) begin
              sq_rem_q <= sq_rem_sh - sq_trial;
            end else begin
              sq_rem_q <= sq_rem_sh;
            end
            sq_cnt_q <= sq_cnt_q + 1'b1;
            if (sq_cnt_q == SQ_CW'(SQ_STEPS - 1)) state_q <= S_MUL;
          end
        end
        S_MUL: begin
          neg_q  <= sq_root_q > root0_q;
          prod_q <= 37'(diff * fsc_pkg::STEER_SCALE);
          state_q <= (den_sum == 9'd0) ? S_DONE : S_DSTART;
          if (den_sum == 9'd0) steer_q <= '0;
          div_zero_q <= (den_sum == 9'd0);
        end
        S_DSTART: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            steer_q <= neg_q ? fsc_pkg::STEER_W'(-div_quot)
                             : fsc_pkg::STEER_W'(div_quot);
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/field_sensor_calibrate_and_steer.sv -----
// Top level of the field sensor calibrate-and-steer block.
// Depends on fsc_pkg, fsc_front, fsc_fifo, fsc_div and fsc_back.
//
// Usage:
//  - Slave stream s_axis_*: one word per ADC sample set (three 12-bit
//    conversions), tuser carries the calibration enable. Bit 0 of each
//    conversion is ignored.
//  - Every SAMPLES_PER_FRAME-th word closes a frame; the front end folds it
//    into the sums, updates the calibration peaks when calibration is enabled
//    and queues the frame. Master stream m_axis_*: one word per frame with three levels and the
//    Q8 steering error; tuser is the zero-denominator flag.
//  - Non-closing words are taken every cycle. In the back end a frame goes
//    through three divisions for the levels, two 20-step square roots, one
//    multiply and, unless the level sum is zero, a final division, all on the
//    shared iterative divider and root unit. The back end works on one frame
//    at a time while the front end goes on taking words into the queue.
//  - A two-frame queue decouples the ends; only a closing word waits when
//    the queue is full.
//  - When the receiver stalls, the result holds in the output register and
//    the back end finishes the next frame, then waits.
//  - Reset clears sums, count, peaks and queue, and marks calibration idle.
`timescale 1ns / 1ps
module field_sensor_calibrate_and_steer #(
  parameter int unsigned SAMPLES_PER_FRAME = fsc_pkg::SPF_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // sample_ch0, sample_ch1, sample_ch2, zero pad
  input  logic [0:0]  s_axis_tuser,   // calib_enable
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // level_ch0, level_ch1, level_ch2, steer_q8, pad
  output logic [0:0]  m_axis_tuser    // div_zero
);
  fsc_pkg::frame_t push_data, pop_data;
  logic push, pop, q_full, q_empty;
  logic [3*fsc_pkg::LEVEL_W-1:0] levels;
  logic [fsc_pkg::STEER_W-1:0] steer;
  logic div_zero;

  fsc_front #(.SAMPLES_PER_FRAME(SAMPLES_PER_FRAME)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .samples_i(s_axis_tdata[35:0]), .calib_enable_i(s_axis_tuser[0]),
    .q_full_i(q_full), .q_push_o(push), .q_data_o(push_data)
  );

  fsc_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_data), .full_o(q_full),
    .pop_i(pop), .empty_o(q_empty), .data_o(pop_data)
  );

  fsc_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_data_i(pop_data), .q_pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .levels_o(levels), .steer_o(steer), .div_zero_o(div_zero)
  );

  assign m_axis_tdata = {1'b0, steer, levels};
  assign m_axis_tuser = div_zero;
endmodule

// ----- rtl/fsc_checker.sv -----
// Port-level checks for field_sensor_calibrate_and_steer, bound to the top.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module fsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_zero_steer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[38:21] == 18'd0)
    else $error("steer nonzero with zero denominator");

  a_flag_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[20:0] == 21'd0)))
    else $error("zero flag disagrees with levels");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[6:0] <= 7'd100 && m_axis_tdata[13:7] <= 7'd100
                      && m_axis_tdata[20:14] <= 7'd100)
    else $error("level above 100");
endmodule

bind field_sensor_calibrate_and_steer fsc_checker u_fsc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser)
);
